// ===== hw/rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that must hold at every clock edge.
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// A condition that must hold in the same cycle as its trigger.
`define ASSERT_IMPL(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |-> (cond)) else $error(msg);

// A condition that must hold in the cycle after its trigger.
`define ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

// ===== hw/rtl/itp_pkg.sv =====
// ----------------------------------------------------------------------------
// itp_pkg
// Types, character codes and helper functions of the infix-to-postfix block.
// ----------------------------------------------------------------------------
package itp_pkg;

  localparam int STACK_DEPTH_DEF = 16;

  // ASCII characters that the converter recognises.
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_OPEN  = 8'h28;
  localparam logic [7:0] CH_CLOSE = 8'h29;

  // Codes held on the operator stack.
  typedef logic [2:0] code_t;
  localparam code_t CODE_PAREN = 3'd0;
  localparam code_t CODE_CARET = 3'd1;
  localparam code_t CODE_STAR  = 3'd2;
  localparam code_t CODE_SLASH = 3'd3;
  localparam code_t CODE_PLUS  = 3'd4;
  localparam code_t CODE_MINUS = 3'd5;

  typedef enum logic [1:0] {
    KIND_OPERAND,
    KIND_OPEN,
    KIND_CLOSE,
    KIND_OP
  } kind_t;

  typedef struct packed {
    kind_t kind;
    code_t code;
  } sym_class_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic latch;      // capture the incoming transaction
    logic rd_top;     // read the current top of stack
    logic set_flush;  // enter the final flush phase
    logic pop;        // emit the top operator and pop it
    logic post;       // push, close or pass the operand through
    logic end_emit;   // emit the end-of-expression result
    logic err_emit;   // emit the error status result
    logic retire;     // hand the held result on as the last one
  } itp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pop_cond;
    logic slot_ok;
    logic out_free;
    logic hold_valid;
    logic flush;
    logic fin;
    logic operand;
    logic err;
  } itp_stat_t;

  function automatic sym_class_t classify(input logic [7:0] ch);
    sym_class_t c;
    c.kind = KIND_OPERAND;
    c.code = CODE_PAREN;
    case (ch)
      CH_CARET: begin c.kind = KIND_OP; c.code = CODE_CARET; end
      CH_STAR:  begin c.kind = KIND_OP; c.code = CODE_STAR;  end
      CH_SLASH: begin c.kind = KIND_OP; c.code = CODE_SLASH; end
      CH_PLUS:  begin c.kind = KIND_OP; c.code = CODE_PLUS;  end
      CH_MINUS: begin c.kind = KIND_OP; c.code = CODE_MINUS; end
      CH_OPEN:  c.kind = KIND_OPEN;
      CH_CLOSE: c.kind = KIND_CLOSE;
      default:  c.kind = KIND_OPERAND;
    endcase
    return c;
  endfunction

  // A lower rank binds tighter.
  function automatic logic [2:0] op_rank(input code_t code);
    logic [2:0] r;
    case (code)
      CODE_CARET: r = 3'd2;
      CODE_STAR:  r = 3'd3;
      CODE_SLASH: r = 3'd3;
      CODE_PLUS:  r = 3'd4;
      CODE_MINUS: r = 3'd4;
      default:    r = 3'd0;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] code_char(input code_t code);
    logic [7:0] ch;
    case (code)
      CODE_CARET: ch = CH_CARET;
      CODE_STAR:  ch = CH_STAR;
      CODE_SLASH: ch = CH_SLASH;
      CODE_PLUS:  ch = CH_PLUS;
      CODE_MINUS: ch = CH_MINUS;
      default:    ch = CH_OPEN;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/infix_to_postfix_converter.sv =====
// ----------------------------------------------------------------------------
// infix_to_postfix_converter
// Shunting-yard converter: infix characters in, postfix characters out.
// ----------------------------------------------------------------------------
//
//   Channel  Direction  Handshake            Payload
//   input    in         in_valid / in_stall  symbol, final_symbol
//   output   out        out_valid / out_stall
//                                            out_symbol, symbol_valid, run_end,
//                                            expression_end, error
//
// An operand or an open parenthesis is latched, posted and retired; an operator
// or a close parenthesis first pops the operators that it must emit. A final
// character adds a flush of every operator left and then the end result. Pops
// run one a cycle while the output has room, paced by the single read port of
// the operator stack memory. Reset is synchronous and leaves the stack holding
// only its sentinel; the memory needs no clearing pass. Output stalls hold it all.
//
// Each input transaction is taken only when the sequencer is idle. Results
// are passed through a one-entry holding register so that the last result of
// a run can be marked with run_end once the run is known to be over; the
// output register behind it lets the next result be built while the previous
// one waits to be taken.
//
module infix_to_postfix_converter #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] symbol,
  input  logic       final_symbol,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_symbol,
  output logic       symbol_valid,
  output logic       run_end,
  output logic       expression_end,
  output logic       error
);
  import itp_pkg::*;

  // Commands and status between the sequencer and the datapath.
  itp_cmd_t  cmd;
  itp_stat_t stat;

  // The sequencer walks each transaction through read, pop, post, flush, end or
  // error, and retire steps.
  itp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // The datapath owns the stack memory, the count and the result registers.
  itp_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .symbol         (symbol),
    .final_symbol   (final_symbol),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_symbol     (out_symbol),
    .symbol_valid   (symbol_valid),
    .run_end        (run_end),
    .expression_end (expression_end),
    .error          (error)
  );

endmodule

// ===== hw/rtl/itp_ctrl.sv =====
// ----------------------------------------------------------------------------
// itp_ctrl
// Sequencer that steps the datapath through one input transaction.
// ----------------------------------------------------------------------------
module itp_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  itp_pkg::itp_stat_t stat,
  output itp_pkg::itp_cmd_t  cmd
);
  import itp_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_POP,
    S_REREAD,
    S_END,
    S_ERR,
    S_DONE
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.latch  = 1'b1;
          cmd.rd_top = 1'b1;
          state_next = S_POP;
        end
      end
      S_POP: begin
        if (stat.pop_cond) begin
          cmd.pop = stat.slot_ok;
        end else if (stat.flush) begin
          state_next = S_END;
        end else if (!stat.operand || stat.slot_ok) begin
          cmd.post   = 1'b1;
          state_next = stat.fin ? S_REREAD : S_ERR;
        end
      end
      S_REREAD: begin
        cmd.rd_top    = 1'b1;
        cmd.set_flush = 1'b1;
        state_next    = S_POP;
      end
      S_END: begin
        if (stat.slot_ok) begin
          cmd.end_emit = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_ERR: begin
        if (!stat.err) begin
          state_next = S_DONE;
        end else if (stat.slot_ok) begin
          cmd.err_emit = 1'b1;
          state_next   = S_DONE;
        end
      end
      S_DONE: begin
        if (!stat.hold_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.retire = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/itp_dpath.sv =====
// ----------------------------------------------------------------------------
// itp_dpath
// Operator stack memory, stack count, held result and output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module itp_dpath #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic [7:0]         symbol,
  input  logic               final_symbol,
  input  itp_pkg::itp_cmd_t  cmd,
  output itp_pkg::itp_stat_t stat,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [7:0]         out_symbol,
  output logic               symbol_valid,
  output logic               run_end,
  output logic               expression_end,
  output logic               error
);
  import itp_pkg::*;

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int IW = (STACK_DEPTH > 2) ? $clog2(STACK_DEPTH) : 1;

  // Latched transaction.
  logic [7:0] sym;
  logic       fin;
  kind_t      kind;
  code_t      code;
  sym_class_t cls;

  // Stack control.
  logic [CW-1:0] count;
  logic          err;
  logic          flush;

  // Stack memory with a registered read port.
  code_t         mem [STACK_DEPTH];
  code_t         rd_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;
  logic          wr_en;

  // Held result, waiting to learn whether it is the last of its run.
  logic [7:0] h_sym;
  logic       h_valid;
  logic       h_eoe;
  logic       h_err;
  logic       hold_valid;

  logic [CW-1:0] cnt_m1;
  logic [CW-1:0] cnt_m2;
  logic [CW-1:0] cnt_p1;
  logic          above1;
  logic          above2;
  logic          full;
  logic          out_free;
  logic          slot_ok;
  logic          pop_cond;
  logic          push;
  logic          bad;
  logic          emit;
  logic [7:0]    e_sym;
  logic          e_valid;
  logic          e_eoe;
  logic          e_err;

  assign cls    = classify(symbol);
  assign cnt_m1 = count - CW'(1);
  assign cnt_m2 = count - CW'(2);
  assign cnt_p1 = count + CW'(1);
  assign above1 = count > CW'(1);
  assign above2 = count > CW'(2);
  assign full   = count == CW'(STACK_DEPTH);

  assign out_free = !out_valid || !out_stall;
  assign slot_ok  = !hold_valid || out_free;

  assign pop_cond = above1 && (rd_data != CODE_PAREN) &&
                    ((kind == KIND_CLOSE) || flush ||
                     ((kind == KIND_OP) && (op_rank(rd_data) <= op_rank(code))));

  assign push  = cmd.post && ((kind == KIND_OP) || (kind == KIND_OPEN));
  assign wr_en = push && !full;
  // Overflow on a push, or a close that finds only the sentinel.
  assign bad   = (push && full) || (cmd.post && (kind == KIND_CLOSE) && !above1);

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_m1[IW-1:0];
    if (cmd.rd_top) begin
      rd_en = above1;
    end else if (cmd.pop) begin
      rd_en   = above2;
      rd_addr = cnt_m2[IW-1:0];
    end
  end

  always_comb begin
    emit    = 1'b0;
    e_sym   = 8'd0;
    e_valid = 1'b0;
    e_eoe   = 1'b0;
    e_err   = 1'b0;
    if (cmd.pop) begin
      emit    = 1'b1;
      e_sym   = code_char(rd_data);
      e_valid = 1'b1;
    end else if (cmd.post && (kind == KIND_OPERAND)) begin
      emit    = 1'b1;
      e_sym   = sym;
      e_valid = 1'b1;
    end else if (cmd.end_emit) begin
      emit  = 1'b1;
      e_eoe = 1'b1;
      e_err = err || above1;
    end else if (cmd.err_emit) begin
      emit  = 1'b1;
      e_err = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[count[IW-1:0]] <= code;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      sym  <= symbol;
      fin  <= final_symbol;
      kind <= cls.kind;
      code <= cls.code;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= CW'(1);
      err   <= 1'b0;
      flush <= 1'b0;
    end else begin
      if (cmd.latch) begin
        err   <= 1'b0;
        flush <= 1'b0;
      end
      if (cmd.set_flush) begin
        flush <= 1'b1;
      end
      if (cmd.pop) begin
        count <= cnt_m1;
      end
      if (cmd.post) begin
        if (bad) begin
          err   <= 1'b1;
          count <= CW'(1);
        end else if (push) begin
          count <= cnt_p1;
        end else if (kind == KIND_CLOSE) begin
          count <= cnt_m1;
        end
      end
      if (cmd.end_emit) begin
        count <= CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      hold_valid <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      if (emit) begin
        if (hold_valid) begin
          out_valid <= 1'b1;
        end
        hold_valid <= 1'b1;
      end
      if (cmd.retire) begin
        out_valid  <= 1'b1;
        hold_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if ((emit && hold_valid) || cmd.retire) begin
      out_symbol     <= h_sym;
      symbol_valid   <= h_valid;
      expression_end <= h_eoe;
      error          <= h_err;
      run_end        <= cmd.retire;
    end
    if (emit) begin
      h_sym   <= e_sym;
      h_valid <= e_valid;
      h_eoe   <= e_eoe;
      h_err   <= e_err;
    end
  end

  assign stat.pop_cond   = pop_cond;
  assign stat.slot_ok    = slot_ok;
  assign stat.out_free   = out_free;
  assign stat.hold_valid = hold_valid;
  assign stat.flush      = flush;
  assign stat.fin        = fin;
  assign stat.operand    = (kind == KIND_OPERAND);
  assign stat.err        = err;

  `ASSERT_ALWAYS(a_count_range, (count >= CW'(1)) && (count <= CW'(STACK_DEPTH)), "stack count out of range")
  `ASSERT_IMPL(a_emit_slot, emit, slot_ok, "result produced with no room to hold it")
  `ASSERT_NEXT(a_end_clears, cmd.end_emit, count == CW'(1), "stack not cleared after expression end")

endmodule

// ===== tb/expression_checker.sv =====
// ----------------------------------------------------------------------------
// expression_checker
// Watches both channels of the infix-to-postfix converter, predicts the
// postfix stream of every accepted character and compares each result.
// ----------------------------------------------------------------------------
module expression_checker #(
  parameter int STACK_DEPTH = itp_pkg::STACK_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic [7:0] symbol,
  input  logic       final_symbol,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic [7:0] out_symbol,
  input  logic       symbol_valid,
  input  logic       run_end,
  input  logic       expression_end,
  input  logic       error,
  output int         mismatches,
  output int         expected_left
);
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       ch_valid;
    logic       run_last;
    logic       expr_last;
    logic       fault;
  } postfix_item_t;

  code_t         op_stack [STACK_DEPTH];
  int unsigned   stack_fill;
  postfix_item_t run_q[$];
  postfix_item_t postfix_q[$];
  postfix_item_t seen;
  postfix_item_t want;
  int            fail_total = 0;

  // A lower rank binds tighter.
  function automatic logic [2:0] binding_rank(input code_t c);
    case (c)
      CODE_CARET:             return 3'd2;
      CODE_STAR, CODE_SLASH:  return 3'd3;
      default:                return 3'd4;
    endcase
  endfunction

  function automatic logic [7:0] op_symbol(input code_t c);
    case (c)
      CODE_CARET: return CH_CARET;
      CODE_STAR:  return CH_STAR;
      CODE_SLASH: return CH_SLASH;
      CODE_PLUS:  return CH_PLUS;
      CODE_MINUS: return CH_MINUS;
      default:    return CH_OPEN;
    endcase
  endfunction

  task automatic emit(input logic [7:0] c, input logic v, input logic e, input logic f);
    postfix_item_t r;
    r.ch        = c;
    r.ch_valid  = v;
    r.run_last  = 1'b0;
    r.expr_last = e;
    r.fault     = f;
    run_q.push_back(r);
  endtask

  task automatic clear_stack();
    op_stack[0] = CODE_PAREN;
    stack_fill  = 1;
  endtask

  function automatic bit push_code(input code_t c);
    if (stack_fill >= STACK_DEPTH) return 1'b0;
    op_stack[stack_fill] = c;
    stack_fill++;
    return 1'b1;
  endfunction

  task automatic unwind_to_paren();
    while (stack_fill > 0 && op_stack[stack_fill-1] != CODE_PAREN) begin
      emit(op_symbol(op_stack[stack_fill-1]), 1'b1, 1'b0, 1'b0);
      stack_fill--;
    end
  endtask

  // Works out every result that one accepted character causes.
  task automatic convert_symbol(input logic [7:0] ch, input logic fin);
    code_t         code;
    logic          is_op;
    logic          fault;
    postfix_item_t last;
    run_q.delete();
    fault = 1'b0;
    is_op = 1'b1;
    code  = CODE_PAREN;
    case (ch)
      CH_CARET: code = CODE_CARET;
      CH_STAR:  code = CODE_STAR;
      CH_SLASH: code = CODE_SLASH;
      CH_PLUS:  code = CODE_PLUS;
      CH_MINUS: code = CODE_MINUS;
      default:  is_op = 1'b0;
    endcase
    if (is_op) begin
      while (stack_fill > 0 && op_stack[stack_fill-1] != CODE_PAREN &&
             binding_rank(op_stack[stack_fill-1]) <= binding_rank(code)) begin
        emit(op_symbol(op_stack[stack_fill-1]), 1'b1, 1'b0, 1'b0);
        stack_fill--;
      end
      if (!push_code(code)) begin
        fault = 1'b1;
        clear_stack();
      end
    end else if (ch == CH_OPEN) begin
      if (!push_code(CODE_PAREN)) begin
        fault = 1'b1;
        clear_stack();
      end
    end else if (ch == CH_CLOSE) begin
      unwind_to_paren();
      if (stack_fill <= 1) begin
        fault = 1'b1;
        clear_stack();
      end else begin
        stack_fill--;
      end
    end else begin
      emit(ch, 1'b1, 1'b0, 1'b0);
    end

    if (fin) begin
      unwind_to_paren();
      if (stack_fill > 1) fault = 1'b1;
      clear_stack();
      emit(8'h00, 1'b0, 1'b1, fault);
    end else if (fault) begin
      emit(8'h00, 1'b0, 1'b0, 1'b1);
    end

    if (run_q.size() > 0) begin
      last = run_q.pop_back();
      last.run_last = 1'b1;
      run_q.push_back(last);
    end
    foreach (run_q[i]) postfix_q.push_back(run_q[i]);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      clear_stack();
      postfix_q.delete();
    end else begin
      if (in_valid && !in_stall) convert_symbol(symbol, final_symbol);
      if (out_valid && !out_stall) begin
        seen = {out_symbol, symbol_valid, run_end, expression_end, error};
        if (postfix_q.size() == 0) begin
          fail_total++;
          if (fail_total <= 10)
            $display("%0t: unexpected result sym=%02h valid=%b run_end=%b expr_end=%b err=%b",
                     $time, seen.ch, seen.ch_valid, seen.run_last, seen.expr_last, seen.fault);
        end else begin
          want = postfix_q.pop_front();
          if (seen !== want) begin
            fail_total++;
            if (fail_total <= 10)
              $display("%0t: mismatch expected sym=%02h valid=%b run_end=%b expr_end=%b err=%b %s",
                       $time, want.ch, want.ch_valid, want.run_last, want.expr_last,
                       want.fault, "");
            if (fail_total <= 10)
              $display("%0t:          actual   sym=%02h valid=%b run_end=%b expr_end=%b err=%b",
                       $time, seen.ch, seen.ch_valid, seen.run_last, seen.expr_last, seen.fault);
          end
        end
      end
    end
    mismatches    <= fail_total;
    expected_left <= postfix_q.size();
  end

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Drives expressions into the infix-to-postfix converter under varied idling
// and a long output hold-off, and gives the verdict from the checker's count.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import itp_pkg::*;

  localparam int DEPTH           = STACK_DEPTH_DEF;
  // The longest stretch with no transaction on either channel before the run
  // is declared hung. The deliberate hold-off below is far shorter.
  localparam int IDLE_LIMIT      = 2000;
  localparam int HOLD_OFF_CYCLES = 200;
  localparam int DRAIN_CYCLES    = 40;
  localparam int PHASE_ITEMS     = 28;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] symbol = 8'h00;
  logic       final_symbol = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_symbol;
  logic       symbol_valid;
  logic       run_end;
  logic       expression_end;
  logic       error;

  int mismatches;
  int expected_left;

  // Idling rates in percent. The sender's rate is only used by the stimulus
  // process; the receiver's rate is written with nonblocking assignments so
  // that the receiver samples it cleanly at the clock edge.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Hold-off requests are counted here and served by the receiver process.
  int hold_off_requests = 0;
  int hold_off_served   = 0;
  int hold_left         = 0;

  int idle_cycles = 0;
  int sent_count  = 0;

  logic [7:0] expr_q[$];

  infix_to_postfix_converter #(
    .STACK_DEPTH(DEPTH)
  ) dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .symbol        (symbol),
    .final_symbol  (final_symbol),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_symbol    (out_symbol),
    .symbol_valid  (symbol_valid),
    .run_end       (run_end),
    .expression_end(expression_end),
    .error         (error)
  );

  expression_checker #(
    .STACK_DEPTH(DEPTH)
  ) checker_i (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .symbol        (symbol),
    .final_symbol  (final_symbol),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_symbol    (out_symbol),
    .symbol_valid  (symbol_valid),
    .run_end       (run_end),
    .expression_end(expression_end),
    .error         (error),
    .mismatches    (mismatches),
    .expected_left (expected_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // The receiver stalls at random at the current rate. When a hold-off is
  // requested it keeps the stall high for a long stretch, counted here, so
  // that the converter's output registers fill and it stalls its own input.
  always @(posedge clk) begin
    if (hold_off_requests != hold_off_served) begin
      hold_off_served <= hold_off_requests;
      hold_left       <= HOLD_OFF_CYCLES;
      out_stall       <= 1'b1;
    end else begin
      if (hold_left > 0) hold_left <= hold_left - 1;
      out_stall <= (hold_left > 1) || ($urandom_range(0, 99) < recv_stall_pct);
    end
  end

  // Watchdog: any transaction on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Offers one character and waits until the converter takes it. The valid
  // is only lowered when an idle gap is drawn, so back-to-back transactions
  // keep it high without a glitch.
  task automatic send_symbol(input logic [7:0] ch, input logic fin);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    symbol       <= ch;
    final_symbol <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_count++;
  endtask

  // Sends the characters held in expr_q, marking the last one as final.
  task automatic send_expression();
    foreach (expr_q[i]) send_symbol(expr_q[i], i == expr_q.size() - 1);
  endtask

  // Any byte except the recognised characters. Flipping bit 6 moves each of
  // those onto a byte that is not recognised, so every bit of the operand still varies.
  function automatic logic [7:0] random_operand();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    case (b)
      CH_CARET, CH_STAR, CH_SLASH, CH_PLUS, CH_MINUS, CH_OPEN, CH_CLOSE: b = b ^ 8'h40;
      default: ;
    endcase
    return b;
  endfunction

  function automatic logic [7:0] random_operator();
    case ($urandom_range(0, 4))
      0:       return CH_CARET;
      1:       return CH_STAR;
      2:       return CH_SLASH;
      3:       return CH_PLUS;
      default: return CH_MINUS;
    endcase
  endfunction

  // Builds a balanced expression. A high open_pct with a large max_nest
  // makes deep nesting, which now and then runs the operator stack over.
  task automatic build_wellformed(input int open_pct, input int max_nest, input int max_terms);
    int nest;
    int n_terms;
    expr_q.delete();
    nest    = 0;
    n_terms = $urandom_range(1, max_terms);
    for (int t = 0; t < n_terms; t++) begin
      while (nest < max_nest && $urandom_range(0, 99) < open_pct) begin
        expr_q.push_back(CH_OPEN);
        nest++;
      end
      expr_q.push_back(random_operand());
      while (nest > 0 && $urandom_range(0, 2) == 0) begin
        expr_q.push_back(CH_CLOSE);
        nest--;
      end
      if (t < n_terms - 1) expr_q.push_back(random_operator());
    end
    while (nest > 0) begin
      expr_q.push_back(CH_CLOSE);
      nest--;
    end
  endtask

  // Noise: a short run of bytes that are mostly operators and parentheses,
  // with the final flag set at random inside the run and always at its end.
  task automatic send_noise();
    int         n;
    logic [7:0] ch;
    n = $urandom_range(1, 10);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 3))
        0:       ch = 8'($urandom_range(0, 255));
        1:       ch = random_operator();
        2:       ch = CH_OPEN;
        default: ch = CH_CLOSE;
      endcase
      send_symbol(ch, (i == n - 1) || ($urandom_range(0, 7) == 0));
    end
  endtask

  task automatic send_random_expression();
    int pick;
    int spot;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      send_noise();
    end else if (pick < 25) begin
      // A balanced expression broken by one stray or missing character.
      build_wellformed(25, 6, 6);
      spot = $urandom_range(0, expr_q.size());
      case ($urandom_range(0, 2))
        0: expr_q.insert(spot, CH_CLOSE);
        1: expr_q.insert(spot, CH_OPEN);
        default: if (expr_q.size() > 1) expr_q.delete($urandom_range(0, expr_q.size() - 1));
      endcase
      send_expression();
    end else if (pick < 35) begin
      build_wellformed(75, DEPTH + 2, 4);
      send_expression();
    end else begin
      build_wellformed(25, 6, 8);
      send_expression();
    end
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input bit squeeze);
    int phase_end;
    send_idle_pct   = idle_pct;
    recv_stall_pct <= stall_pct;
    if (squeeze) hold_off_requests <= hold_off_requests + 1;
    phase_end = sent_count + PHASE_ITEMS;
    while (sent_count < phase_end) send_random_expression();
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Every operator in an order that both pops (equal or
    // tighter rank on the stack) and holds back (looser rank on the stack),
    // opened and closed by the extreme operand bytes.
    expr_q = '{8'h00, CH_PLUS, CH_STAR, CH_CARET, CH_SLASH, CH_MINUS, 8'hFF};
    send_expression();
    // An unmatched close on a non-final character gives a separate error
    // transaction; an open left over at the final character flags the end.
    expr_q = '{CH_CLOSE, CH_OPEN};
    send_expression();
    // Sixteen opens: the last one finds the stack full, on a final character.
    expr_q.delete();
    repeat (DEPTH) expr_q.push_back(CH_OPEN);
    send_expression();

    // Random part, one phase per idling pattern. The first phase also holds
    // the output off for a long stretch while the sender keeps offering.
    run_phase(0, 0, 1'b1);
    run_phase(58, 0, 1'b0);
    run_phase(0, 58, 1'b0);
    run_phase(6, 6, 1'b0);

    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_left != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0 && expected_left == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/itp_pkg.sv
hw/rtl/itp_ctrl.sv
hw/rtl/itp_dpath.sv
hw/rtl/infix_to_postfix_converter.sv
tb/expression_checker.sv
tb/tb.sv
